@@ sv/vector3_arithmetic_unit_core_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the vector arithmetic unit checker
// Expect signals named clock and reset in the scope of each use.
// ----------------------------------------------------------------------------
`ifndef VECTOR3_ARITHMETIC_UNIT_CORE_ASSERT_SVH
`define VECTOR3_ARITHMETIC_UNIT_CORE_ASSERT_SVH

// same-cycle implication
`define VAU_ASSERT_IMP(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("vau check failed");

// next-cycle implication
`define VAU_ASSERT_NXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("vau check failed");

`endif

@@ sv/vau_pkg.sv @@
// ----------------------------------------------------------------------------
// vau_pkg
// Types, constants and the saturation helper of the vector arithmetic unit.
// ----------------------------------------------------------------------------
package vau_pkg;

   localparam int WORD_BITS     = 32;
   localparam int FRAC_BITS_DEF = 16;
   localparam int ROOT_BITS     = 32;
   localparam int QUEUE_DEPTH   = 4;

   localparam logic [31:0] S32_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] S32_MIN = 32'h8000_0000;

   localparam logic signed [65:0] SAT_HI = 66'sd2147483647;
   localparam logic signed [65:0] SAT_LO = -SAT_HI - 66'sd1;

   typedef enum logic [2:0] {
      MODE_ADD   = 3'd0,
      MODE_SUB   = 3'd1,
      MODE_SCALE = 3'd2,
      MODE_DIV   = 3'd3,
      MODE_DOT   = 3'd4,
      MODE_MAG   = 3'd5,
      MODE_MAGSQ = 3'd6,
      MODE_NORM  = 3'd7
   } mode_type;

   typedef struct packed {
      logic is_add;
      logic is_sub;
      logic is_scale;
      logic is_div;
      logic is_dot;
      logic is_mag;
      logic is_magsq;
      logic is_norm;
      logic div_zero;
      logic mul_a;
      logic mul_s;
   } cls_type;

   typedef struct packed {
      cls_type          cls;
      logic [2:0][31:0] a;
      logic [2:0][31:0] b;
      logic [31:0]      s;
   } item_type;

   typedef struct packed {
      cls_type          cls;
      logic [2:0][31:0] a;
      logic [31:0]      s;
      logic [2:0][63:0] p;
      logic [2:0][32:0] as;
   } mul_type;

   typedef struct packed {
      cls_type          cls;
      logic [2:0][31:0] a;
      logic [31:0]      s;
      logic [2:0][31:0] vec;
      logic [31:0]      sc;
      logic             ov;
      logic [31:0]      root;
   } side_type;

   typedef struct packed {
      logic [31:0] value;
      logic        ov;
   } sat_type;

   function automatic sat_type sat32(input logic signed [65:0] v);
      sat_type r;
      if (v > SAT_HI) begin
         r.value = S32_MAX;
         r.ov    = 1'b1;
      end else if (v < SAT_LO) begin
         r.value = S32_MIN;
         r.ov    = 1'b1;
      end else begin
         r.value = v[31:0];
         r.ov    = 1'b0;
      end
      return r;
   endfunction

endpackage

@@ sv/vau_sqrt.sv @@
// ----------------------------------------------------------------------------
// vau_sqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module vau_sqrt (
   input  logic        clock,
   input  logic        en,
   input  logic [63:0] in_n,
   output logic [31:0] out_root
);
   import vau_pkg::*;

   localparam int N_W   = 2 * ROOT_BITS;
   localparam int REM_W = ROOT_BITS + 2;
   localparam int CUR_W = ROOT_BITS + 4;

   logic [N_W-1:0]       n_ff     [ROOT_BITS];
   logic [N_W-1:0]       n_in     [ROOT_BITS];
   logic [REM_W-1:0]     rem_ff   [ROOT_BITS];
   logic [REM_W-1:0]     rem_in   [ROOT_BITS];
   logic [ROOT_BITS-1:0] root_ff  [ROOT_BITS];
   logic [ROOT_BITS-1:0] root_in  [ROOT_BITS];
   logic [N_W-1:0]       n_prev   [ROOT_BITS];
   logic [REM_W-1:0]     rem_prev [ROOT_BITS];
   logic [ROOT_BITS-1:0] root_prev[ROOT_BITS];
   logic [CUR_W-1:0]     cur      [ROOT_BITS];
   logic [CUR_W-1:0]     trial    [ROOT_BITS];

   always_comb begin
      for (int k = 0; k < ROOT_BITS; k++) begin
         if (k == 0) begin
            n_prev[k]    = in_n;
            rem_prev[k]  = '0;
            root_prev[k] = '0;
         end else begin
            n_prev[k]    = n_ff[k-1];
            rem_prev[k]  = rem_ff[k-1];
            root_prev[k] = root_ff[k-1];
         end
         // bring down the next two radicand bits
         cur[k]   = {rem_prev[k], n_prev[k][N_W-1:N_W-2]};
         trial[k] = {2'b00, root_prev[k], 2'b01};
         n_in[k]  = {n_prev[k][N_W-3:0], 2'b00};
         if (cur[k] >= trial[k]) begin
            rem_in[k]  = REM_W'(cur[k] - trial[k]);
            root_in[k] = {root_prev[k][ROOT_BITS-2:0], 1'b1};
         end else begin
            rem_in[k]  = cur[k][REM_W-1:0];
            root_in[k] = {root_prev[k][ROOT_BITS-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < ROOT_BITS; k++) begin
            n_ff[k]    <= n_in[k];
            rem_ff[k]  <= rem_in[k];
            root_ff[k] <= root_in[k];
         end
      end
   end

   assign out_root = root_ff[ROOT_BITS-1];

endmodule

@@ sv/vau_div.sv @@
// ----------------------------------------------------------------------------
// vau_div
// Pipelined unsigned restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module vau_div #(
   parameter int DVD_W = vau_pkg::WORD_BITS + vau_pkg::FRAC_BITS_DEF
) (
   input  logic             clock,
   input  logic             en,
   input  logic [DVD_W-1:0] in_dividend,
   input  logic [31:0]      in_divisor,
   output logic [DVD_W-1:0] out_quot
);
   import vau_pkg::*;

   logic [DVD_W-1:0]     dvd_ff   [DVD_W];
   logic [DVD_W-1:0]     dvd_in   [DVD_W];
   logic [DVD_W-1:0]     quot_ff  [DVD_W];
   logic [DVD_W-1:0]     quot_in  [DVD_W];
   logic [WORD_BITS-1:0] rem_ff   [DVD_W];
   logic [WORD_BITS-1:0] rem_in   [DVD_W];
   logic [WORD_BITS-1:0] dsr_ff   [DVD_W];
   logic [WORD_BITS-1:0] dsr_in   [DVD_W];
   logic [DVD_W-1:0]     dvd_prev [DVD_W];
   logic [DVD_W-1:0]     quot_prev[DVD_W];
   logic [WORD_BITS-1:0] rem_prev [DVD_W];
   logic [WORD_BITS:0]   cur      [DVD_W];
   logic                 ge       [DVD_W];

   always_comb begin
      for (int k = 0; k < DVD_W; k++) begin
         if (k == 0) begin
            dvd_prev[k]  = in_dividend;
            quot_prev[k] = '0;
            rem_prev[k]  = '0;
            dsr_in[k]    = in_divisor;
         end else begin
            dvd_prev[k]  = dvd_ff[k-1];
            quot_prev[k] = quot_ff[k-1];
            rem_prev[k]  = rem_ff[k-1];
            dsr_in[k]    = dsr_ff[k-1];
         end
         cur[k]     = {rem_prev[k], dvd_prev[k][DVD_W-1]};
         ge[k]      = cur[k] >= {1'b0, dsr_in[k]};
         rem_in[k]  = ge[k] ? WORD_BITS'(cur[k] - {1'b0, dsr_in[k]})
                            : cur[k][WORD_BITS-1:0];
         quot_in[k] = {quot_prev[k][DVD_W-2:0], ge[k]};
         dvd_in[k]  = {dvd_prev[k][DVD_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < DVD_W; k++) begin
            dvd_ff[k]  <= dvd_in[k];
            quot_ff[k] <= quot_in[k];
            rem_ff[k]  <= rem_in[k];
            dsr_ff[k]  <= dsr_in[k];
         end
      end
   end

   assign out_quot = quot_ff[DVD_W-1];

endmodule

@@ sv/vau_front.sv @@
// ----------------------------------------------------------------------------
// vau_front
// Accepts request items, decodes the mode and queues them for the back end.
// ----------------------------------------------------------------------------
module vau_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_mode,
   input  logic signed [31:0] req_ax,
   input  logic signed [31:0] req_ay,
   input  logic signed [31:0] req_az,
   input  logic signed [31:0] req_bx,
   input  logic signed [31:0] req_by,
   input  logic signed [31:0] req_bz,
   input  logic signed [31:0] req_scalar_in,
   output logic               q_valid,
   input  logic               q_pop,
   output vau_pkg::item_type  q_item
);
   import vau_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   item_type         slot_ff [QUEUE_DEPTH];
   item_type         slot_in;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   mode_type         mode;
   cls_type          cls;

   always_comb begin
      mode = mode_type'(req_mode);
      cls  = '0;
      case (mode)
         MODE_ADD:   cls.is_add   = 1'b1;
         MODE_SUB:   cls.is_sub   = 1'b1;
         MODE_SCALE: cls.is_scale = 1'b1;
         MODE_DIV:   cls.is_div   = 1'b1;
         MODE_DOT:   cls.is_dot   = 1'b1;
         MODE_MAG:   cls.is_mag   = 1'b1;
         MODE_MAGSQ: cls.is_magsq = 1'b1;
         MODE_NORM:  cls.is_norm  = 1'b1;
         default:    cls = '0;
      endcase
      cls.div_zero = (req_scalar_in == '0);
      cls.mul_a    = cls.is_mag | cls.is_magsq | cls.is_norm;
      cls.mul_s    = cls.is_scale;
   end

   always_comb begin
      slot_in.cls = cls;
      slot_in.a   = {req_az, req_ay, req_ax};
      slot_in.b   = {req_bz, req_by, req_bx};
      slot_in.s   = req_scalar_in;
   end

   assign req_stall = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
   assign rd_ptr_in = q_pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
   assign count_in  = count_ff + CNT_W'(push) - CNT_W'(q_pop);

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign q_valid = (count_ff != '0);
   assign q_item  = slot_ff[rd_ptr_ff];

endmodule

@@ sv/vau_back.sv @@
// ----------------------------------------------------------------------------
// vau_back
// Execution pipeline: multipliers, sums, square root, dividers and result mux.
// ----------------------------------------------------------------------------
module vau_back #(
   parameter int FRAC_BITS = vau_pkg::FRAC_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  vau_pkg::item_type q_item,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [31:0]       rsp_rx,
   output logic [31:0]       rsp_ry,
   output logic [31:0]       rsp_rz,
   output logic [31:0]       rsp_scalar_out,
   output logic              rsp_div_zero,
   output logic              rsp_overflow
);
   import vau_pkg::*;

   localparam int DVD_W = WORD_BITS + FRAC_BITS;

   logic adv;

   // stage 1: products and sums
   logic [2:0][31:0] mul_b;
   mul_type          st1_ff, st1_in;
   logic             v1_ff;

   // stage 2: saturate vector results, sum the products
   side_type          side2_ff, side2_in;
   logic signed [65:0] sum2_ff, sum2_in;
   sat_type          scl [3];
   sat_type          ads [3];
   logic             v2_ff;

   // stage 3: scalar results, radicand
   side_type         side3_ff, side3_in;
   logic [63:0]      n3_ff;
   sat_type          dsat;
   logic             v3_ff;

   // root and divide lines
   side_type             sq_ff [ROOT_BITS];
   logic [ROOT_BITS-1:0] vsq_ff, vsq_in;
   logic [31:0]          root;
   side_type             dv_side_in;
   side_type             dv_ff [DVD_W];
   logic [DVD_W-1:0]     vdv_ff, vdv_in;
   logic [31:0]          divisor;
   logic [2:0][31:0]     mag_a;
   logic [DVD_W-1:0]     dividend [3];
   logic [DVD_W-1:0]     quot [3];

   // result
   side_type            dve;
   logic                neg [3];
   logic signed [65:0]  qs [3];
   sat_type             qsat [3];
   sat_type             rsat;
   logic [2:0][31:0]    vec_in;
   logic [31:0]         sc_in;
   logic                ov_in, dz_in;
   logic [31:0]         rx_ff, ry_ff, rz_ff, sc_ff;
   logic                dz_ff, ov_ff;
   logic                rsp_valid_ff, rsp_valid_in;

   // hold the whole pipe while a result waits
   assign adv   = !(rsp_valid_ff && rsp_stall);
   assign q_pop = q_valid && adv;

   always_comb begin
      st1_in.cls = q_item.cls;
      st1_in.a   = q_item.a;
      st1_in.s   = q_item.s;
      for (int i = 0; i < 3; i++) begin
         mul_b[i] = q_item.cls.mul_s ? q_item.s
                  : (q_item.cls.mul_a ? q_item.a[i] : q_item.b[i]);
         st1_in.p[i] = 64'($signed(q_item.a[i]) * $signed(mul_b[i]));
         st1_in.as[i] = q_item.cls.is_sub
                      ? 33'($signed(q_item.a[i])) - 33'($signed(q_item.b[i]))
                      : 33'($signed(q_item.a[i])) + 33'($signed(q_item.b[i]));
      end
   end

   always_comb begin
      side2_in.cls  = st1_ff.cls;
      side2_in.a    = st1_ff.a;
      side2_in.s    = st1_ff.s;
      side2_in.vec  = '0;
      side2_in.sc   = '0;
      side2_in.ov   = 1'b0;
      side2_in.root = '0;
      for (int i = 0; i < 3; i++) begin
         scl[i] = sat32(66'($signed(st1_ff.p[i])) >>> FRAC_BITS);
         ads[i] = sat32(66'($signed(st1_ff.as[i])));
         if (st1_ff.cls.is_add || st1_ff.cls.is_sub) begin
            side2_in.vec[i] = ads[i].value;
            side2_in.ov     = side2_in.ov | ads[i].ov;
         end else if (st1_ff.cls.is_scale) begin
            side2_in.vec[i] = scl[i].value;
            side2_in.ov     = side2_in.ov | scl[i].ov;
         end
      end
      sum2_in = 66'($signed(st1_ff.p[0])) + 66'($signed(st1_ff.p[1]))
              + 66'($signed(st1_ff.p[2]));
   end

   always_comb begin
      dsat     = sat32(sum2_ff >>> FRAC_BITS);
      side3_in = side2_ff;
      if (side2_ff.cls.is_dot || side2_ff.cls.is_magsq) begin
         side3_in.sc = dsat.value;
         side3_in.ov = dsat.ov;
      end
   end

   vau_sqrt u_sqrt (
      .clock    (clock),
      .en       (adv),
      .in_n     (n3_ff),
      .out_root (root)
   );

   always_comb begin
      dv_side_in      = sq_ff[ROOT_BITS-1];
      dv_side_in.root = root;
      divisor = dv_side_in.cls.is_div
              ? (dv_side_in.s[31] ? 32'(-dv_side_in.s) : dv_side_in.s)
              : root;
      for (int i = 0; i < 3; i++) begin
         mag_a[i]    = dv_side_in.a[i][31] ? 32'(-dv_side_in.a[i]) : dv_side_in.a[i];
         dividend[i] = {mag_a[i], {FRAC_BITS{1'b0}}};
      end
   end

   for (genvar g = 0; g < 3; g++) begin : g_div
      vau_div #(.DVD_W(DVD_W)) u_div (
         .clock       (clock),
         .en          (adv),
         .in_dividend (dividend[g]),
         .in_divisor  (divisor),
         .out_quot    (quot[g])
      );
   end

   always_comb begin
      dve    = dv_ff[DVD_W-1];
      vec_in = dve.vec;
      sc_in  = dve.sc;
      ov_in  = dve.ov;
      dz_in  = 1'b0;
      rsat   = sat32(66'(dve.root));
      for (int i = 0; i < 3; i++) begin
         neg[i]  = dve.a[i][31] ^ (dve.cls.is_div & dve.s[31]);
         qs[i]   = neg[i] ? -$signed(66'(quot[i])) : $signed(66'(quot[i]));
         qsat[i] = sat32(qs[i]);
      end
      if (dve.cls.is_div) begin
         if (dve.cls.div_zero) begin
            dz_in = 1'b1;
            for (int i = 0; i < 3; i++) begin
               vec_in[i] = dve.a[i][31] ? S32_MIN
                         : ((dve.a[i] == '0) ? '0 : S32_MAX);
            end
         end else begin
            for (int i = 0; i < 3; i++) begin
               vec_in[i] = qsat[i].value;
               ov_in     = ov_in | qsat[i].ov;
            end
         end
      end
      if (dve.cls.is_norm) begin
         // zero vector passes through unchanged
         for (int i = 0; i < 3; i++) begin
            vec_in[i] = (dve.root == '0) ? dve.a[i] : qsat[i].value;
         end
      end
      if (dve.cls.is_mag) begin
         sc_in = rsat.value;
         ov_in = rsat.ov;
      end
   end

   assign vsq_in       = {vsq_ff[ROOT_BITS-2:0], v3_ff};
   assign vdv_in       = {vdv_ff[DVD_W-2:0], vsq_ff[ROOT_BITS-1]};
   assign rsp_valid_in = vdv_ff[DVD_W-1];

   always_ff @(posedge clock) begin
      if (adv) begin
         st1_ff   <= st1_in;
         side2_ff <= side2_in;
         sum2_ff  <= sum2_in;
         side3_ff <= side3_in;
         n3_ff    <= sum2_ff[63:0];
         sq_ff[0] <= side3_ff;
         for (int k = 1; k < ROOT_BITS; k++) begin
            sq_ff[k] <= sq_ff[k-1];
         end
         dv_ff[0] <= dv_side_in;
         for (int k = 1; k < DVD_W; k++) begin
            dv_ff[k] <= dv_ff[k-1];
         end
         rx_ff <= vec_in[0];
         ry_ff <= vec_in[1];
         rz_ff <= vec_in[2];
         sc_ff <= sc_in;
         dz_ff <= dz_in;
         ov_ff <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         vsq_ff       <= '0;
         vdv_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         v1_ff        <= q_valid;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         vsq_ff       <= vsq_in;
         vdv_ff       <= vdv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_rx         = rx_ff;
   assign rsp_ry         = ry_ff;
   assign rsp_rz         = rz_ff;
   assign rsp_scalar_out = sc_ff;
   assign rsp_div_zero   = dz_ff;
   assign rsp_overflow   = ov_ff;

endmodule

@@ sv/vector3_arithmetic_unit_core.sv @@
// ----------------------------------------------------------------------------
// vector3_arithmetic_unit_core
// Three-component Q-format vector unit: add, subtract, scale, divide, dot,
// magnitude, squared magnitude and normalize.
//
// Request channel req_*: mode, vectors a and b, scalar. An item moves when
// req_valid is high and req_stall is low. Response channel rsp_*: vector,
// scalar, div_zero and overflow flags; one response per request, in order.
// Q16.16 by default. From request to response an item passes through
// three stages for products and sums (the first takes the item from the
// input queue), 32 for the root pipeline and 32 + FRAC_BITS for the divider
// pipeline, plus the output register. All stages advance together, one
// per clock, and take one item per cycle unless frozen as described below.
// While rsp_stall holds a waiting response, the pipe freezes and a four-entry
// queue keeps taking requests; req_stall rises only when it is full.
// Synchronous reset empties the queue and drops all items in flight.
// ----------------------------------------------------------------------------
module vector3_arithmetic_unit_core #(
   parameter int FRAC_BITS = vau_pkg::FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_mode,
   input  logic signed [31:0] req_ax,
   input  logic signed [31:0] req_ay,
   input  logic signed [31:0] req_az,
   input  logic signed [31:0] req_bx,
   input  logic signed [31:0] req_by,
   input  logic signed [31:0] req_bz,
   input  logic signed [31:0] req_scalar_in,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_rx,
   output logic signed [31:0] rsp_ry,
   output logic signed [31:0] rsp_rz,
   output logic signed [31:0] rsp_scalar_out,
   output logic               rsp_div_zero,
   output logic               rsp_overflow
);
   import vau_pkg::*;

   logic     q_valid;
   logic     q_pop;
   item_type q_item;

   vau_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_mode      (req_mode),
      .req_ax        (req_ax),
      .req_ay        (req_ay),
      .req_az        (req_az),
      .req_bx        (req_bx),
      .req_by        (req_by),
      .req_bz        (req_bz),
      .req_scalar_in (req_scalar_in),
      .q_valid       (q_valid),
      .q_pop         (q_pop),
      .q_item        (q_item)
   );

   vau_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_item         (q_item),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_rx         (rsp_rx),
      .rsp_ry         (rsp_ry),
      .rsp_rz         (rsp_rz),
      .rsp_scalar_out (rsp_scalar_out),
      .rsp_div_zero   (rsp_div_zero),
      .rsp_overflow   (rsp_overflow)
   );

endmodule

@@ sv/vau_checker.sv @@
// ----------------------------------------------------------------------------
// vau_checker
// Port-level checks of the vector arithmetic unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "vector3_arithmetic_unit_core_assert.svh"

module vau_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_rx,
   input logic [31:0] rsp_ry,
   input logic [31:0] rsp_rz,
   input logic [31:0] rsp_scalar_out,
   input logic        rsp_div_zero,
   input logic        rsp_overflow
);
   import vau_pkg::*;

   logic rsp_wait;
   logic any_clamp;

   assign rsp_wait  = rsp_valid && rsp_stall;
   assign any_clamp = (rsp_rx == S32_MAX) || (rsp_rx == S32_MIN)
                    || (rsp_ry == S32_MAX) || (rsp_ry == S32_MIN)
                    || (rsp_rz == S32_MAX) || (rsp_rz == S32_MIN)
                    || (rsp_scalar_out == S32_MAX) || (rsp_scalar_out == S32_MIN);

   // a stalled response stays put
   `VAU_ASSERT_NXT(a_rsp_hold, rsp_wait, rsp_valid && $stable(rsp_rx) && $stable(rsp_scalar_out))

   // a zero divisor saturates each nonzero component without overflow and leaves the scalar clear
   `VAU_ASSERT_IMP(a_dz_clean, rsp_valid && rsp_div_zero, !rsp_overflow && rsp_scalar_out == '0)

   // overflow always leaves a clamped value behind
   `VAU_ASSERT_IMP(a_ov_clamped, rsp_valid && rsp_overflow, any_clamp)

endmodule

bind vector3_arithmetic_unit_core vau_checker u_checker (.*);
